// ===== hdl/vcr_pkg.sv =====
// Package for the vertex compaction and remap block.
// Holds sizes, operation and status codes, state type and the structs that
// run between the controller and the top level. Depends on nothing.
package vcr_pkg;

    localparam int unsigned VERTEX_DEPTH = 1024;
    localparam int unsigned VERTEX_BITS  = 32;
    localparam int unsigned IDX_W        = $clog2(VERTEX_DEPTH);
    localparam int unsigned CNT_W        = IDX_W + 1;

    // Operation codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_ADD     = 3'd0,
        MODE_MARK    = 3'd1,
        MODE_COMPACT = 3'd2,
        MODE_REMAP   = 3'd3,
        MODE_READ    = 3'd4,
        MODE_CLEAR   = 3'd5
    } t_mode;

    // Status codes returned with every result word
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NO_TABLE = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WAIT,
        S_SWEEP
    } t_state;

    // One result word
    typedef struct packed {
        t_status                 status;
        logic [IDX_W-1:0]        result_index;
        logic                    result_valid;
        logic [VERTEX_BITS-1:0]  vertex_out;
        logic [CNT_W-1:0]        removed_count;
        logic [CNT_W-1:0]        vertex_count;
    } t_result;

    // Memory port controls driven by the controller
    typedef struct packed {
        logic                    vtx_we;
        logic [IDX_W-1:0]        vtx_waddr;
        logic [VERTEX_BITS-1:0]  vtx_wdata;
        logic [IDX_W-1:0]        vtx_raddr;
        logic                    mark_we;
        logic [IDX_W-1:0]        mark_waddr;
        logic                    mark_wdata;
        logic [IDX_W-1:0]        mark_raddr;
        logic                    remap_we;
        logic [IDX_W-1:0]        remap_waddr;
        logic [CNT_W-1:0]        remap_wdata;
        logic [IDX_W-1:0]        remap_raddr;
    } t_mem_req;

endpackage

// ===== hdl/vcr_if.sv =====
// Valid/ready channel interfaces for the vertex compaction and remap block.
// Depends on vcr_pkg for the field widths.
interface vcr_in_if import vcr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [2:0]              mode;
    logic [VERTEX_BITS-1:0]  vertex_data;
    logic [IDX_W-1:0]        vertex_index;

    modport source (output valid, output mode, output vertex_data, output vertex_index,
                    input ready);
    modport sink   (input valid, input mode, input vertex_data, input vertex_index,
                    output ready);
endinterface

interface vcr_out_if import vcr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [IDX_W-1:0]        result_index;
    logic                    result_valid;
    logic [VERTEX_BITS-1:0]  vertex_out;
    logic [CNT_W-1:0]        removed_count;
    logic [CNT_W-1:0]        vertex_count;

    modport source (output valid, output status, output result_index, output result_valid,
                    output vertex_out, output removed_count, output vertex_count,
                    input ready);
    modport sink   (input valid, input status, input result_index, input result_valid,
                    input vertex_out, input removed_count, input vertex_count,
                    output ready);
endinterface

// ===== hdl/vcr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module vcr_ram #(
    parameter  int unsigned WIDTH = 32,
    parameter  int unsigned DEPTH = 1024,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/vcr_ctrl.sv =====
// Controller of the vertex compaction and remap block: decodes each word,
// drives the three RAMs and runs the compaction sweep. Depends on vcr_pkg.
module vcr_ctrl import vcr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [2:0]              i_mode,
    input  logic [VERTEX_BITS-1:0]  i_vertex_data,
    input  logic [IDX_W-1:0]        i_vertex_index,
    input  logic [VERTEX_BITS-1:0]  i_vtx_rdata,
    input  logic                    i_mark_rdata,
    input  logic [CNT_W-1:0]        i_remap_rdata,
    output t_mem_req                o_req,
    output t_result                 o_res,
    output logic                    o_res_load,
    output logic                    o_idle
);

    t_state            r_state,        n_state;
    logic [CNT_W-1:0]  r_count,        n_count;
    logic [CNT_W-1:0]  r_count_before, n_count_before;
    logic              r_remap_ready,  n_remap_ready;
    logic [CNT_W-1:0]  r_rd_ptr,       n_rd_ptr;
    logic              r_rd_vld,       n_rd_vld;
    logic [IDX_W-1:0]  r_rd_addr,      n_rd_addr;
    logic [CNT_W-1:0]  r_next,         n_next;
    t_mode             r_hold_mode,    n_hold_mode;
    logic [CNT_W-1:0]  removed;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_count_before <= '0;
            r_remap_ready  <= 1'b0;
            r_rd_ptr       <= '0;
            r_rd_vld       <= 1'b0;
            r_next         <= '0;
            r_hold_mode    <= MODE_READ;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_count_before <= n_count_before;
            r_remap_ready  <= n_remap_ready;
            r_rd_ptr       <= n_rd_ptr;
            r_rd_vld       <= n_rd_vld;
            r_next         <= n_next;
            r_hold_mode    <= n_hold_mode;
        end
    end

    // Sweep address follows the issued read
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
    end

    assign removed = r_count - r_next;
    assign o_idle  = (r_state == S_IDLE);

    // Next state, memory controls and result word
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_count_before = r_count_before;
        n_remap_ready  = r_remap_ready;
        n_rd_ptr       = r_rd_ptr;
        n_rd_vld       = r_rd_vld;
        n_rd_addr      = r_rd_addr;
        n_next         = r_next;
        n_hold_mode    = r_hold_mode;

        o_req             = '0;
        o_req.vtx_raddr   = (r_state == S_SWEEP) ? r_rd_ptr[IDX_W-1:0] : i_vertex_index;
        o_req.mark_raddr  = r_rd_ptr[IDX_W-1:0];
        o_req.remap_raddr = i_vertex_index;

        o_res              = '0;
        o_res.status       = ST_OK;
        o_res.vertex_count = r_count;
        o_res_load         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    case (t_mode'(i_mode))
                        MODE_ADD: begin
                            o_res_load = 1'b1;
                            if (r_count >= CNT_W'(VERTEX_DEPTH)) begin
                                o_res.status = ST_FULL;
                            end else begin
                                // Append and clear any stale mark on the new entry
                                o_req.vtx_we       = 1'b1;
                                o_req.vtx_waddr    = r_count[IDX_W-1:0];
                                o_req.vtx_wdata    = i_vertex_data;
                                o_req.mark_we      = 1'b1;
                                o_req.mark_waddr   = r_count[IDX_W-1:0];
                                o_req.mark_wdata   = 1'b0;
                                o_res.result_index = r_count[IDX_W-1:0];
                                n_count            = r_count + CNT_W'(1);
                                o_res.vertex_count = n_count;
                            end
                        end
                        MODE_MARK: begin
                            o_res_load = 1'b1;
                            if (CNT_W'(i_vertex_index) >= r_count) begin
                                o_res.status = ST_RANGE;
                            end else begin
                                o_req.mark_we    = 1'b1;
                                o_req.mark_waddr = i_vertex_index;
                                o_req.mark_wdata = 1'b1;
                            end
                        end
                        MODE_COMPACT: begin
                            n_state  = S_SWEEP;
                            n_rd_ptr = '0;
                            n_rd_vld = 1'b0;
                            n_next   = '0;
                        end
                        MODE_REMAP: begin
                            if (!r_remap_ready) begin
                                o_res_load   = 1'b1;
                                o_res.status = ST_NO_TABLE;
                            end else if (CNT_W'(i_vertex_index) >= r_count_before) begin
                                o_res_load   = 1'b1;
                                o_res.status = ST_RANGE;
                            end else begin
                                n_state     = S_WAIT;
                                n_hold_mode = MODE_REMAP;
                            end
                        end
                        MODE_READ: begin
                            if (CNT_W'(i_vertex_index) >= r_count) begin
                                o_res_load   = 1'b1;
                                o_res.status = ST_RANGE;
                            end else begin
                                n_state     = S_WAIT;
                                n_hold_mode = MODE_READ;
                            end
                        end
                        MODE_CLEAR: begin
                            o_res_load         = 1'b1;
                            n_count            = '0;
                            o_res.vertex_count = '0;
                        end
                        default: begin
                            o_res_load = 1'b1;
                        end
                    endcase
                end
            end

            S_WAIT: begin
                // RAM data is back: build the result
                o_res_load = 1'b1;
                n_state    = S_IDLE;
                if (r_hold_mode == MODE_READ) begin
                    o_res.vertex_out = i_vtx_rdata;
                end else if (!i_remap_rdata[IDX_W]) begin
                    o_res.result_valid = 1'b1;
                    o_res.result_index = i_remap_rdata[IDX_W-1:0];
                end
            end

            S_SWEEP: begin
                // Issue the next read while entries remain
                if (r_rd_ptr < r_count) begin
                    n_rd_ptr  = r_rd_ptr + CNT_W'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_rd_ptr[IDX_W-1:0];
                end else begin
                    n_rd_vld = 1'b0;
                end

                if (r_rd_vld) begin
                    // Write the table entry, drop the mark, move kept vertices down
                    o_req.remap_we    = 1'b1;
                    o_req.remap_waddr = r_rd_addr;
                    o_req.mark_we     = 1'b1;
                    o_req.mark_waddr  = r_rd_addr;
                    o_req.mark_wdata  = 1'b0;
                    if (i_mark_rdata) begin
                        o_req.remap_wdata = r_next;
                        o_req.vtx_we      = 1'b1;
                        o_req.vtx_waddr   = r_next[IDX_W-1:0];
                        o_req.vtx_wdata   = i_vtx_rdata;
                        n_next            = r_next + CNT_W'(1);
                    end else begin
                        o_req.remap_wdata = CNT_W'(VERTEX_DEPTH);
                    end
                end else if (r_rd_ptr >= r_count) begin
                    // Pass complete: report and commit the new size
                    o_res_load          = 1'b1;
                    o_res.removed_count = removed;
                    o_res.vertex_count  = r_next;
                    n_count             = r_next;
                    n_count_before      = r_count;
                    n_remap_ready       = (removed != '0);
                    n_state             = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The write pointer of the sweep never overtakes the read pointer
    a_next_behind_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_next <= r_rd_ptr))
        else $error("compaction write pointer ahead of read pointer");

    // Moved vertices land at or below the entry just read
    a_move_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && o_req.vtx_we) |-> (o_req.vtx_waddr <= r_rd_addr))
        else $error("compaction moves a vertex upward");

    // Store size stays within the RAM
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VERTEX_DEPTH))
        else $error("vertex count beyond store depth");

    // A result is produced only when the item is finished
    a_load_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_load |=> (r_state == S_IDLE))
        else $error("result loaded while item still busy");

    // A finished compaction leaves no more vertices than it started with
    a_compact_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && o_res_load) |=> (r_count <= r_count_before))
        else $error("compaction grew the store");

endmodule

// ===== hdl/vertex_compaction_remap.sv =====
// Vertex compaction and remap: a vertex store with used marks, compaction into an
// old-to-new index table, remap lookup and read. Add, mark, clear, unused codes and
// any word rejected with a status load their result in the accepting cycle; read and
// remap first wait in S_WAIT for the registered read data of the vertex and table RAMs;
// compact runs a sweep: it accepts the word, issues one RAM read per stored entry,
// then drains the last read and commits. A new word is taken only when the
// previous result has left the output register or leaves in the same cycle. No
// clearing pass follows reset: each append clears the mark of its new entry, so marks
// above the current count are never seen.
// Depends on vcr_pkg, vcr_if, vcr_ram and vcr_ctrl.
module vertex_compaction_remap import vcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vcr_in_if.sink    i_in,
    vcr_out_if.source o_out
);

    t_mem_req               req;
    t_result                res;
    logic                   res_load;
    logic                   idle;
    logic                   accept;
    logic [VERTEX_BITS-1:0] vtx_rdata;
    logic [0:0]             mark_rdata;
    logic [CNT_W-1:0]       remap_rdata;

    t_result                r_out;
    logic                   r_out_vld;

    // Take a word when idle and the output register is free or draining
    assign i_in.ready = idle && (!r_out_vld || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    vcr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_mode         (i_in.mode),
        .i_vertex_data  (i_in.vertex_data),
        .i_vertex_index (i_in.vertex_index),
        .i_vtx_rdata    (vtx_rdata),
        .i_mark_rdata   (mark_rdata[0]),
        .i_remap_rdata  (remap_rdata),
        .o_req          (req),
        .o_res          (res),
        .o_res_load     (res_load),
        .o_idle         (idle)
    );

    vcr_ram #(.WIDTH(VERTEX_BITS), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (req.vtx_we),
        .i_waddr (req.vtx_waddr),
        .i_wdata (req.vtx_wdata),
        .i_raddr (req.vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    vcr_ram #(.WIDTH(1), .DEPTH(VERTEX_DEPTH)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (req.mark_we),
        .i_waddr (req.mark_waddr),
        .i_wdata (req.mark_wdata),
        .i_raddr (req.mark_raddr),
        .o_rdata (mark_rdata)
    );

    vcr_ram #(.WIDTH(CNT_W), .DEPTH(VERTEX_DEPTH)) u_remap_ram (
        .i_clk   (i_clk),
        .i_we    (req.remap_we),
        .i_waddr (req.remap_waddr),
        .i_wdata (req.remap_wdata),
        .i_raddr (req.remap_raddr),
        .o_rdata (remap_rdata)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.status        = r_out.status;
    assign o_out.result_index  = r_out.result_index;
    assign o_out.result_valid  = r_out.result_valid;
    assign o_out.vertex_out    = r_out.vertex_out;
    assign o_out.removed_count = r_out.removed_count;
    assign o_out.vertex_count  = r_out.vertex_count;

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |-> !res_load)
        else $error("result overwritten before it was taken");

    // Words are taken only while the controller is idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> idle)
        else $error("word accepted while controller busy");

    // A result load implies room in the output register
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_out_vld || o_out.ready))
        else $error("result loaded into a full output register");

endmodule

// ===== test/vcr_checker.sv =====
// Scoreboard for the vertex compaction and remap block: watches both channels,
// predicts every result word from its own copy of the store, and compares.
// Depends on vcr_pkg and the channel interfaces in vcr_if.
module vcr_checker import vcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    vcr_in_if    i_in,
    vcr_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_table_builds
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow state of the block
    logic [VERTEX_BITS-1:0] vtx_mem [VERTEX_DEPTH];
    logic [CNT_W-1:0]       new_index [VERTEX_DEPTH];
    bit                     used [VERTEX_DEPTH];
    logic [CNT_W-1:0]       held = '0;
    logic [CNT_W-1:0]       held_at_compact = '0;
    logic                   table_live = 1'b0;

    // Result words still owed by the block, oldest first
    t_result want_q [$];

    int fail_cnt     = 0;
    int checked_cnt  = 0;
    int builds_cnt   = 0;
    int pending_cnt  = 0;

    assign o_fail_count   = fail_cnt;
    assign o_pending      = pending_cnt;
    assign o_checked      = checked_cnt;
    assign o_table_builds = builds_cnt;

    // Apply one accepted word to the shadow state and return the word it should produce
    function automatic t_result predict_word(input logic [2:0]             mode,
                                             input logic [VERTEX_BITS-1:0] data,
                                             input logic [IDX_W-1:0]       idx);
        t_result r;
        int      kept;
        r = '0;
        case (mode)
            MODE_ADD: begin
                if (held >= VERTEX_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    vtx_mem[held[IDX_W-1:0]] = data;
                    r.result_index = held[IDX_W-1:0];
                    held           = held + 1'b1;
                end
            end
            MODE_MARK: begin
                if ({1'b0, idx} >= held) r.status = ST_RANGE;
                else used[idx] = 1'b1;
            end
            MODE_COMPACT: begin
                // squeeze marked entries down in order and build the old-to-new table
                kept = 0;
                for (int k = 0; k < held; k++) begin
                    if (used[k]) begin
                        new_index[k] = CNT_W'(kept);
                        vtx_mem[kept] = vtx_mem[k];
                        kept++;
                    end else begin
                        new_index[k] = CNT_W'(VERTEX_DEPTH);
                    end
                end
                r.removed_count = CNT_W'(int'(held) - kept);
                held_at_compact = held;
                held            = CNT_W'(kept);
                table_live      = (r.removed_count != '0);
                used            = '{default: 1'b0};
                if (table_live) builds_cnt++;
            end
            MODE_REMAP: begin
                if (!table_live) begin
                    r.status = ST_NO_TABLE;
                end else if ({1'b0, idx} >= held_at_compact) begin
                    r.status = ST_RANGE;
                end else if (new_index[idx] < VERTEX_DEPTH) begin
                    r.result_index = new_index[idx][IDX_W-1:0];
                    r.result_valid = 1'b1;
                end
            end
            MODE_READ: begin
                if ({1'b0, idx} >= held) r.status = ST_RANGE;
                else r.vertex_out = vtx_mem[idx];
            end
            MODE_CLEAR: begin
                held = '0;
                used = '{default: 1'b0};
            end
            default: ;
        endcase
        r.vertex_count = held;
        return r;
    endfunction

    // Compare one result word field by field
    task automatic compare_word(input t_result want, input t_result got);
        checked_cnt++;
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
        end
        if (got.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index, got.result_index);
            fail_cnt++;
        end
        if (got.result_valid !== want.result_valid) begin
            $error("result_valid: expected %0d, got %0d", want.result_valid, got.result_valid);
            fail_cnt++;
        end
        if (got.vertex_out !== want.vertex_out) begin
            $error("vertex_out: expected %08h, got %08h", want.vertex_out, got.vertex_out);
            fail_cnt++;
        end
        if (got.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, got %0d", want.removed_count,
                   got.removed_count);
            fail_cnt++;
        end
        if (got.vertex_count !== want.vertex_count) begin
            $error("vertex_count: expected %0d, got %0d", want.vertex_count, got.vertex_count);
            fail_cnt++;
        end
    endtask

    // Predict on each accepted input word, check each accepted result word
    always @(posedge i_clk) begin : watch
        t_result got;
        if (!i_rst_n) begin
            held            = '0;
            held_at_compact = '0;
            table_live      = 1'b0;
            used            = '{default: 1'b0};
            want_q.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                want_q = {want_q,
                          predict_word(i_in.mode, i_in.vertex_data, i_in.vertex_index)};
            if (i_out.valid && i_out.ready) begin
                got.status        = t_status'(i_out.status);
                got.result_index  = i_out.result_index;
                got.result_valid  = i_out.result_valid;
                got.vertex_out    = i_out.vertex_out;
                got.removed_count = i_out.removed_count;
                got.vertex_count  = i_out.vertex_count;
                if (want_q.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fail_cnt++;
                end else begin
                    compare_word(want_q.pop_front(), got);
                end
            end
        end
        pending_cnt <= want_q.size();
    end

endmodule

// ===== test/tb.sv =====
// Top of the testbench for the vertex compaction and remap block: clock, reset,
// bursty word source, stalling result sink, watchdog and verdict.
// Depends on vcr_pkg, vcr_if, the block itself and vcr_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vcr_pkg::*;

    // Codes the block leaves unused
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 750;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} t_rx_style;

    logic i_clk    = 1'b0;
    logic i_rst_n  = 1'b0;
    logic rx_ready = 1'b0;

    vcr_in_if  in_ch ();
    vcr_out_if out_ch ();

    int fails;
    int pending;
    int checked;
    int table_builds;

    vertex_compaction_remap uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    vcr_checker scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_fail_count   (fails),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_table_builds (table_builds)
    );

    always #4 i_clk = ~i_clk;

    assign out_ch.ready = rx_ready;

    // Result sink: switch between open, random and sparse stall styles
    t_rx_style  rx_style = RX_OPEN;
    int         rx_left  = 0;
    logic [1:0] rx_phase = '0;

    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_style <= t_rx_style'($urandom_range(0, 2));
            rx_left  <= $urandom_range(16, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1'b1;
        case (rx_style)
            RX_OPEN:   rx_ready <= 1'b1;
            RX_RANDOM: rx_ready <= ($urandom_range(0, 2) != 0);
            default:   rx_ready <= (rx_phase == 2'd3);
        endcase
    end

    // Watchdog: stop when neither channel has moved a word for too long
    int quiet = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Rough picture of the store, used only to aim indices at live entries
    int fill  = 0;
    int span  = 0;
    bit chosen [VERTEX_DEPTH];

    int words_sent = 0;
    int burst_left = 0;

    // Drive one word in bursts with random gaps, hold until taken, then track it
    task automatic send_word(input logic [2:0]             mode,
                             input logic [VERTEX_BITS-1:0] data,
                             input logic [IDX_W-1:0]       idx);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.vertex_data  <= data;
        in_ch.vertex_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;

        case (mode)
            MODE_ADD:  if (fill < VERTEX_DEPTH) fill++;
            MODE_MARK: if (idx < fill) chosen[idx] = 1'b1;
            MODE_COMPACT: begin
                span = fill;
                fill = 0;
                for (int k = 0; k < span; k++) if (chosen[k]) fill++;
                chosen = '{default: 1'b0};
            end
            MODE_CLEAR: begin
                fill   = 0;
                chosen = '{default: 1'b0};
            end
            default: ;
        endcase
        if (mode <= MODE_CLEAR) words_sent++;
    endtask

    // Mostly a live index below lim, now and then any index at all
    function automatic logic [IDX_W-1:0] pick_below(input int lim);
        if (lim <= 0 || $urandom_range(0, 6) == 0) return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // One well-formed round: fill, mark, compact, then remap and read back
    task automatic run_round();
        int adds;
        adds = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        if (fill + adds > VERTEX_DEPTH || $urandom_range(0, 3) != 0)
            send_word(MODE_CLEAR, $urandom, IDX_W'($urandom));
        repeat (adds) send_word(MODE_ADD, $urandom, IDX_W'($urandom));
        if ($urandom_range(0, 7) == 0) begin
            for (int k = 0; k < fill; k++) send_word(MODE_MARK, $urandom, k[IDX_W-1:0]);
        end else begin
            repeat ($urandom_range(0, adds + 4))
                send_word(MODE_MARK, $urandom, pick_below(fill));
        end
        send_word(MODE_COMPACT, $urandom, IDX_W'($urandom));
        repeat ($urandom_range(1, 8)) send_word(MODE_REMAP, $urandom, pick_below(span));
        repeat ($urandom_range(0, 6)) send_word(MODE_READ, $urandom, pick_below(fill));
    endtask

    // Short run of arbitrary words, spare codes included
    task automatic run_noise();
        repeat ($urandom_range(1, 8))
            send_word(3'($urandom_range(0, 7)), $urandom,
                      IDX_W'(($urandom_range(0, 1) == 1) ? $urandom
                                                         : $urandom_range(0, fill + 1)));
    endtask

    initial begin
        int target;
        in_ch.valid        <= 1'b0;
        in_ch.mode         <= MODE_ADD;
        in_ch.vertex_data  <= '0;
        in_ch.vertex_index <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty store: no table, nothing in range, compaction of nothing
        send_word(MODE_REMAP,   32'h0, 10'd0);
        send_word(MODE_READ,    32'h0, 10'd0);
        send_word(MODE_MARK,    32'h0, 10'd0);
        send_word(MODE_COMPACT, 32'h0, 10'd0);
        // Four vertices with payload extremes, marks in and out of range
        send_word(MODE_ADD,  32'h0000_0000, 10'd0);
        send_word(MODE_ADD,  32'hFFFF_FFFF, 10'd1023);
        send_word(MODE_ADD,  32'hA5A5_A5A5, 10'h2AA);
        send_word(MODE_ADD,  32'h5A5A_5A5A, 10'h155);
        send_word(MODE_MARK, 32'h0, 10'd1);
        send_word(MODE_MARK, 32'h0, 10'd3);
        send_word(MODE_MARK, 32'h0, 10'd3);
        send_word(MODE_MARK, 32'h0, 10'd4);
        send_word(MODE_MARK, 32'h0, 10'd1023);
        send_word(MODE_READ, 32'h0, 10'd3);
        send_word(MODE_READ, 32'h0, 10'd4);
        send_word(MODE_READ, 32'h0, 10'd1023);
        send_word(MODE_SPARE_LO, 32'hFFFF_FFFF, 10'd1023);
        send_word(MODE_SPARE_HI, 32'hFFFF_FFFF, 10'd1023);
        // Compact, then remap kept, removed and out-of-range indices
        send_word(MODE_COMPACT, 32'h0, 10'd0);
        send_word(MODE_REMAP,   32'h0, 10'd0);
        send_word(MODE_REMAP,   32'h0, 10'd1);
        send_word(MODE_REMAP,   32'h0, 10'd3);
        send_word(MODE_REMAP,   32'h0, 10'd4);
        send_word(MODE_REMAP,   32'h0, 10'd1023);
        send_word(MODE_READ,    32'h0, 10'd1);
        // Clear keeps the table; an empty compaction drops it
        send_word(MODE_CLEAR,   32'h0, 10'd0);
        send_word(MODE_REMAP,   32'h0, 10'd3);
        send_word(MODE_COMPACT, 32'h0, 10'd0);
        send_word(MODE_REMAP,   32'h0, 10'd0);

        // Full store: overflow, top index, keep one of 1024, then remove all 1024
        send_word(MODE_CLEAR, 32'h0, 10'd0);
        repeat (VERTEX_DEPTH) send_word(MODE_ADD, $urandom, IDX_W'($urandom));
        send_word(MODE_ADD,     32'hFFFF_FFFF, 10'd1023);
        send_word(MODE_MARK,    32'h0, 10'd1023);
        send_word(MODE_READ,    32'h0, 10'd1023);
        send_word(MODE_COMPACT, 32'h0, 10'd0);
        send_word(MODE_REMAP,   32'h0, 10'd1023);
        send_word(MODE_REMAP,   32'h0, 10'd0);
        send_word(MODE_READ,    32'h0, 10'd0);
        repeat (VERTEX_DEPTH - 1) send_word(MODE_ADD, $urandom, IDX_W'($urandom));
        send_word(MODE_COMPACT, 32'h0, 10'd0);
        send_word(MODE_REMAP,   32'h0, 10'd1023);

        // Random rounds with some noise in between
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            if ($urandom_range(0, 4) == 0) run_noise();
            else run_round();
        end
        in_ch.valid <= 1'b0;

        // Drain: wait for every owed result, then wait out DRAIN_CYCLES
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words (spare codes not counted), checked %0d result words.",
                 words_sent, checked);
        $display("Included two full-store fills and %0d compactions that built a table.",
                 table_builds);
        if (fails == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
